// ----- hw/rtl/lk2_pkg.sv -----
// Package for the lookup2 byte hash: shared types, constants and the mix row function.
// No dependencies; lk2_collect, lk2_mix_pipe and lookup2_byte_hash import it.
`default_nettype none

package lk2_pkg;

    localparam int unsigned BLOCK_LEN = 12;
    localparam int unsigned MIX_ROWS  = 9;
    localparam int unsigned FILL_W    = 4;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } words_t;

    // Finish request: tail lanes, with the byte count already folded into word c.
    typedef struct packed {
        logic        had_block;
        logic [31:0] a_tail;
        logic [31:0] b_tail;
        logic [31:0] c_tail;
    } fin_job_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              had_block;
    } clt_status_t;

    // One row of the mix: two subtracts and a shifted xor into one word.
    function automatic words_t mix_row(input words_t w, input int unsigned row);
        words_t r;
        r = w;
        case (row)
            0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
            1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
            2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
            3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
            4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
            5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
            6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
            7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
            8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lk2_if.sv -----
// Valid/ready channel interfaces for the lookup2 byte hash: byte requests in, hashes out.
// No dependencies.
`default_nettype none

interface lk2_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface lk2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lk2_mix_pipe.sv -----
// Nine-stage pipeline of the lookup2 mix, one row per stage.
// Depends on lk2_pkg.
`default_nettype none

module lk2_mix_pipe
    import lk2_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire logic   in_valid,
    input  wire words_t in_words,
    output logic        out_valid,
    output words_t      out_words
);

    logic [MIX_ROWS-1:0] valid_reg;
    logic [MIX_ROWS-1:0] valid_next;
    words_t              stage_reg [MIX_ROWS];
    words_t              stage_in  [MIX_ROWS];

    assign valid_next = {valid_reg[MIX_ROWS-2:0], in_valid};

    always_comb
    begin
        stage_in[0] = in_words;
        for (int k = 1; k < MIX_ROWS; k++)
        begin
            stage_in[k] = stage_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload loads only behind a valid request, so the last stage holds the newest result.
    for (genvar k = 0; k < MIX_ROWS; k++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (advance && valid_next[k])
            begin
                stage_reg[k] <= mix_row(stage_in[k], k);
            end
        end
    end

    assign out_valid = valid_reg[MIX_ROWS-1];
    assign out_words = stage_reg[MIX_ROWS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/lk2_collect.sv -----
// Byte collector: gathers 12-byte blocks, issues block and finish requests.
// Depends on lk2_pkg.
`default_nettype none

module lk2_collect
    import lk2_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire logic   fire,
    input  wire logic [7:0] data_byte,
    input  wire logic   has_byte,
    input  wire logic   last,
    input  wire words_t chain_words,
    output logic        blk_valid,
    output words_t      blk_words,
    output logic        fin_valid,
    output fin_job_t    fin_job,
    output clt_status_t status
);

    localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(BLOCK_LEN - 1);

    logic [7:0]        bytes_reg [BLOCK_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [31:0]       count_reg;
    logic              had_block_reg;
    logic              had_block_next;
    logic              blk_valid_reg;
    words_t            blk_words_reg;
    logic              fin_valid_reg;
    fin_job_t          fin_job_reg;

    logic [7:0]        eff_bytes [BLOCK_LEN];
    logic [7:0]        tail_bytes [BLOCK_LEN];
    logic              block_done;
    words_t            base;
    words_t            blk_words_next;
    fin_job_t          fin_job_next;

    assign block_done     = has_byte && (fill_reg == LAST_SLOT);
    assign fill_next      = block_done ? '0 : fill_reg + {{(FILL_W-1){1'b0}}, has_byte};
    assign had_block_next = had_block_reg || block_done;

    always_comb
    begin
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            eff_bytes[i]  = (has_byte && fill_reg == FILL_W'(i)) ? data_byte : bytes_reg[i];
            tail_bytes[i] = (FILL_W'(i) < fill_next) ? eff_bytes[i] : 8'h00;
        end
    end

    // Chain on the previous block's mix, or start from the initial words.
    always_comb
    begin
        if (had_block_reg)
        begin
            base = chain_words;
        end
        else
        begin
            base = '{a: GOLDEN, b: GOLDEN, c: 32'h0};
        end
        blk_words_next.a = base.a + {eff_bytes[3], eff_bytes[2], eff_bytes[1], eff_bytes[0]};
        blk_words_next.b = base.b + {eff_bytes[7], eff_bytes[6], eff_bytes[5], eff_bytes[4]};
        blk_words_next.c = base.c + {eff_bytes[11], eff_bytes[10], eff_bytes[9], eff_bytes[8]};
    end

    // Tail lanes do not overlap, so they pack without carries; word c shifts up one byte.
    always_comb
    begin
        fin_job_next.had_block = had_block_next;
        fin_job_next.a_tail = {tail_bytes[3], tail_bytes[2], tail_bytes[1], tail_bytes[0]};
        fin_job_next.b_tail = {tail_bytes[7], tail_bytes[6], tail_bytes[5], tail_bytes[4]};
        fin_job_next.c_tail = count_reg + {tail_bytes[10], tail_bytes[9], tail_bytes[8], 8'h00}
                              + {31'h0, has_byte};
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_byte)
        begin
            bytes_reg[fill_reg] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            count_reg     <= '0;
            had_block_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (last)
            begin
                fill_reg      <= '0;
                count_reg     <= '0;
                had_block_reg <= 1'b0;
            end
            else
            begin
                fill_reg      <= fill_next;
                count_reg     <= count_reg + {31'h0, has_byte};
                had_block_reg <= had_block_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            blk_valid_reg <= fire && block_done;
            fin_valid_reg <= fire && last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire && block_done)
        begin
            blk_words_reg <= blk_words_next;
        end
        if (advance && fire && last)
        begin
            fin_job_reg <= fin_job_next;
        end
    end

    assign blk_valid        = blk_valid_reg;
    assign blk_words        = blk_words_reg;
    assign fin_valid        = fin_valid_reg;
    assign fin_job          = fin_job_reg;
    assign status.fill      = fill_reg;
    assign status.had_block = had_block_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lookup2_byte_hash.sv -----
// Streaming lookup2 32-bit hash over a byte message, one byte request per cycle while not stalled.
// Finish path: collector register, finish delay line, combine register, final mix, output register.
// Throughput: one request per cycle while not stalled, set by the nine-row mix pipelines that advance together.
// A stalled result blocks input only when the next result is about to land behind it.
// Reset (rst_n, async, active low) clears valid bits, fill and byte count; no clearing pass.
// Depends on lk2_pkg, lk2_if, lk2_collect and lk2_mix_pipe.
`default_nettype none

module lookup2_byte_hash
    import lk2_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lk2_in_if.sink    msg,
    lk2_out_if.source hash
);

    // Every stage moves on one shared advance, so the fixed distances below hold under stalls.
    logic        advance;
    logic        fire;

    logic        blk_valid;
    words_t      blk_words;
    logic        fin_valid;
    fin_job_t    fin_job;
    clt_status_t status;

    logic        chain_valid;
    words_t      chain_words;

    // Delay the finish request by the block mix depth: any block of the same message
    // accepted no later than the finish request has left the block pipe by then,
    // while the next message needs twelve more bytes before it can change chain_words.
    logic [MIX_ROWS-1:0] dly_valid_reg;
    fin_job_t            dly_reg [MIX_ROWS];

    logic        comb_valid_reg;
    words_t      comb_words_reg;
    words_t      comb_words_next;
    words_t      comb_base;

    logic        fin_out_valid;
    words_t      fin_out_words;

    logic        out_valid_reg;
    logic [31:0] hash_reg;

    // Hold everything only when a result waits and another one is about to land behind it.
    assign advance   = !out_valid_reg || hash.ready || !fin_out_valid;
    assign msg.ready = advance;
    assign fire      = msg.valid && advance;

    lk2_collect u_collect (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .fire        (fire),
        .data_byte   (msg.data_byte),
        .has_byte    (msg.has_byte),
        .last        (msg.last),
        .chain_words (chain_words),
        .blk_valid   (blk_valid),
        .blk_words   (blk_words),
        .fin_valid   (fin_valid),
        .fin_job     (fin_job),
        .status      (status)
    );

    // Block mix: its last stage keeps the newest mixed words and feeds the next block.
    lk2_mix_pipe u_blk_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (blk_valid),
        .in_words  (blk_words),
        .out_valid (chain_valid),
        .out_words (chain_words)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly_valid_reg <= '0;
        end
        else if (advance)
        begin
            dly_valid_reg <= {dly_valid_reg[MIX_ROWS-2:0], fin_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dly_reg[0] <= fin_job;
            for (int k = 1; k < MIX_ROWS; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    // Add the tail and length onto the words left by the message's blocks, or onto the initial words if it had none.
    always_comb
    begin
        if (dly_reg[MIX_ROWS-1].had_block)
        begin
            comb_base = chain_words;
        end
        else
        begin
            comb_base = '{a: GOLDEN, b: GOLDEN, c: 32'h0};
        end
        comb_words_next.a = comb_base.a + dly_reg[MIX_ROWS-1].a_tail;
        comb_words_next.b = comb_base.b + dly_reg[MIX_ROWS-1].b_tail;
        comb_words_next.c = comb_base.c + dly_reg[MIX_ROWS-1].c_tail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            comb_valid_reg <= dly_valid_reg[MIX_ROWS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dly_valid_reg[MIX_ROWS-1])
        begin
            comb_words_reg <= comb_words_next;
        end
    end

    // Final mix.
    lk2_mix_pipe u_fin_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (comb_valid_reg),
        .in_words  (comb_words_reg),
        .out_valid (fin_out_valid),
        .out_words (fin_out_words)
    );

    // Output register: load a landing result, otherwise drop the valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && fin_out_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (hash.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fin_out_valid)
        begin
            hash_reg <= fin_out_words.c;
        end
    end

    assign hash.valid      = out_valid_reg;
    assign hash.hash_value = hash_reg;

    // Input stalls only behind a waiting result with another one right behind it.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !msg.ready |-> (out_valid_reg && fin_out_valid))
        else $error("input held without a blocked result");

    // A taken result with nothing landing leaves the output empty.
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hash.ready && !fin_out_valid) |=> !out_valid_reg)
        else $error("output valid stuck after result taken");

    // A block leaving the mix with a finish request belongs to that same message.
    a_chain_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid && dly_valid_reg[MIX_ROWS-1]) |-> dly_reg[MIX_ROWS-1].had_block)
        else $error("block mix result ignored by finishing message");

    // Pending bytes never reach a full block between requests.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.fill < FILL_W'(BLOCK_LEN))
        else $error("byte collector fill out of range");

endmodule

`default_nettype wire
